[rtl/smr_pkg.sv]
// Shared types and constants for the square matrix rotator.
package smr_pkg;

   // Element width and rotation register width.
   localparam int VALUE_W = 32;
   localparam int TURNS_W = 2;

   // Default matrix edge length.
   localparam int DEFAULT_MATRIX_SIZE = 8;

   // Depth of the result queue in the drain engine.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   // Rotation codes held in the rotation register.
   localparam logic [TURNS_W-1:0] TURN_NONE = 2'd0;
   localparam logic [TURNS_W-1:0] TURN_90   = 2'd1;
   localparam logic [TURNS_W-1:0] TURN_180  = 2'd2;
   localparam logic [TURNS_W-1:0] TURN_270  = 2'd3;

   localparam logic [TURNS_W-1:0] TURNS_RESET = TURN_90;

   // Drain command handed from the loader to the drain engine.
   typedef struct packed {
      logic               bank;
      logic [TURNS_W-1:0] turns;
   } drain_cmd_type;

   // Bank release sent back by the drain engine when a bank has been read out.
   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

endpackage

[rtl/square_matrix_rotator.sv]
// Top level of the square matrix rotator: loader, command queue and drain engine.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------
//  req      | req_push / req_full    | req_element_value (row-major input)
//  rsp      | rsp_pop / rsp_empty    | rsp_rotated_value, rsp_run_end
//  csr      | csr_valid / csr_ready  | csr_quarter_turns
//
// The loader writes one element per cycle while req_full is low, into one of
// two store banks. The drain engine reads one element per cycle while the
// result queue has room, from the other bank through the store's single read
// port, so a full matrix of N*N elements drains while the next one loads;
// its first result passes the command queue, read port and result queue.
// req_full is high only while both banks hold matrices not yet read out.
// Reset is synchronous; the store is not cleared, since every entry is
// written before it is read. A stalled rsp side holds up to four results.
module square_matrix_rotator #(
   parameter int MATRIX_SIZE = smr_pkg::DEFAULT_MATRIX_SIZE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [smr_pkg::VALUE_W-1:0]  req_element_value,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [smr_pkg::VALUE_W-1:0]  rsp_rotated_value,
   output logic                                rsp_run_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smr_pkg::TURNS_W-1:0]         csr_quarter_turns
);

   localparam int CNT_W = $clog2(MATRIX_SIZE * MATRIX_SIZE);
   localparam int IDX_W = $clog2(MATRIX_SIZE);

   logic                        wr_en;
   logic [CNT_W:0]              wr_addr;
   logic [smr_pkg::VALUE_W-1:0] wr_data;
   logic                        cmd_push;
   logic                        cmd_full;
   logic                        cmd_pop;
   logic                        cmd_valid;
   smr_pkg::drain_cmd_type      cmd_in;
   smr_pkg::drain_cmd_type      cmd_head;
   smr_pkg::bank_release_type   release_info;

   // Loader.
   smr_front #(
      .MATRIX_SIZE (MATRIX_SIZE),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (req_push),
      .full              (req_full),
      .element_value     (req_element_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_quarter_turns (csr_quarter_turns),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .cmd_push          (cmd_push),
      .cmd               (cmd_in),
      .cmd_full          (cmd_full),
      .release_info      (release_info)
   );

   // Command queue between loader and drain engine.
   smr_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .not_empty (cmd_valid),
      .head      (cmd_head)
   );

   // Drain engine with the matrix store.
   smr_back #(
      .MATRIX_SIZE (MATRIX_SIZE),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd_head),
      .cmd_pop       (cmd_pop),
      .release_info  (release_info),
      .empty         (rsp_empty),
      .pop           (rsp_pop),
      .rotated_value (rsp_rotated_value),
      .run_end       (rsp_run_end)
   );

endmodule

[rtl/smr_front.sv]
// Loader: accepts elements, writes them into the current bank and issues drain commands.
module smr_front #(
   parameter int MATRIX_SIZE = smr_pkg::DEFAULT_MATRIX_SIZE,
   parameter int CNT_W       = $clog2(MATRIX_SIZE * MATRIX_SIZE)
) (
   input  logic                                clock,
   input  logic                                reset,
   // Element input
   input  logic                                push,
   output logic                                full,
   input  logic signed [smr_pkg::VALUE_W-1:0]  element_value,
   // Rotation register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smr_pkg::TURNS_W-1:0]         csr_quarter_turns,
   // Store write port
   output logic                                wr_en,
   output logic [CNT_W:0]                      wr_addr,
   output logic [smr_pkg::VALUE_W-1:0]         wr_data,
   // Command queue
   output logic                                cmd_push,
   output smr_pkg::drain_cmd_type              cmd,
   input  logic                                cmd_full,
   // Bank release from the drain engine
   input  smr_pkg::bank_release_type           release_info
);

   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(MATRIX_SIZE * MATRIX_SIZE - 1);

   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        bank_ff, bank_in;
   logic [1:0]                  busy_ff, busy_in;
   logic [smr_pkg::TURNS_W-1:0] turns_ff, turns_in;
   logic                        accept;
   logic                        last_elem;

   // The rotation register can always take a write.
   assign csr_ready = 1'b1;

   // Stall while the bank being loaded still waits to be drained.
   assign full      = busy_ff[bank_ff] | cmd_full;
   assign accept    = push & ~full;
   assign last_elem = (count_ff == LAST_COUNT);

   // Each accepted element goes straight into the store.
   assign wr_en   = accept;
   assign wr_addr = {bank_ff, count_ff};
   assign wr_data = element_value;

   // The completing element hands the bank and the rotation to the drain engine.
   assign cmd_push  = accept & last_elem;
   assign cmd.bank  = bank_ff;
   assign cmd.turns = turns_ff;

   // Next-state logic for the load counter, bank pointer, busy flags and rotation register.
   always_comb begin
      count_in = count_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      turns_in = turns_ff;
      if (csr_valid && csr_ready) begin
         turns_in = csr_quarter_turns;
      end
      if (release_info.valid) begin
         busy_in[release_info.bank] = 1'b0;
      end
      if (accept) begin
         if (last_elem) begin
            count_in         = '0;
            bank_in          = ~bank_ff;
            busy_in[bank_ff] = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
         turns_ff <= smr_pkg::TURNS_RESET;
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
         turns_ff <= turns_in;
      end
   end

`ifndef SYNTHESIS
   // A release must only free a bank that holds an undrained matrix.
   assert property (@(posedge clock) disable iff (reset)
      release_info.valid |-> busy_ff[release_info.bank])
      else $error("release of a bank that is not busy");

   // Completing a load moves loading to the other bank.
   assert property (@(posedge clock) disable iff (reset)
      cmd_push |=> (bank_ff != $past(bank_ff)) && (count_ff == '0))
      else $error("bank did not switch after a completed load");

   // The counter never runs past the last element of a matrix.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_COUNT)
      else $error("load counter out of range");
`endif

endmodule

[rtl/smr_cmd_queue.sv]
// Two-entry queue of drain commands between the loader and the drain engine.
module smr_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  smr_pkg::drain_cmd_type push_cmd,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output smr_pkg::drain_cmd_type head
);

   smr_pkg::drain_cmd_type entry_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/smr_back.sv]
// Drain engine: holds the two-bank store and reads a loaded matrix out in rotated order.
module smr_back #(
   parameter int MATRIX_SIZE = smr_pkg::DEFAULT_MATRIX_SIZE,
   parameter int CNT_W       = $clog2(MATRIX_SIZE * MATRIX_SIZE),
   parameter int IDX_W       = $clog2(MATRIX_SIZE)
) (
   input  logic                                clock,
   input  logic                                reset,
   // Store write port from the loader
   input  logic                                wr_en,
   input  logic [CNT_W:0]                      wr_addr,
   input  logic [smr_pkg::VALUE_W-1:0]         wr_data,
   // Command queue
   input  logic                                cmd_valid,
   input  smr_pkg::drain_cmd_type              cmd,
   output logic                                cmd_pop,
   // Bank release to the loader
   output smr_pkg::bank_release_type           release_info,
   // Result output
   output logic                                empty,
   input  logic                                pop,
   output logic signed [smr_pkg::VALUE_W-1:0]  rotated_value,
   output logic                                run_end
);

   localparam int               STORE_DEPTH = 2 ** (CNT_W + 1);
   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(MATRIX_SIZE - 1);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_RUN  = 2'b10
   } back_state_type;

   back_state_type                       state_ff, state_in;
   logic [smr_pkg::VALUE_W-1:0]          store_ff [STORE_DEPTH];
   logic                                 bank_ff, bank_in;
   logic [smr_pkg::TURNS_W-1:0]          turns_ff, turns_in;
   logic [IDX_W-1:0]                     row_ff, row_in;
   logic [IDX_W-1:0]                     col_ff, col_in;
   logic [IDX_W-1:0]                     src_row;
   logic [IDX_W-1:0]                     src_col;
   logic [CNT_W-1:0]                     src_index;
   logic                                 last_pos;
   logic                                 can_issue;
   logic                                 issue;
   logic [smr_pkg::VALUE_W-1:0]          rd_data_ff;
   logic                                 rd_last_ff;
   logic                                 pend_ff;
   logic [smr_pkg::VALUE_W-1:0]          out_data_ff [smr_pkg::OUT_DEPTH];
   logic                                 out_last_ff [smr_pkg::OUT_DEPTH];
   logic [smr_pkg::OUT_PTR_W-1:0]        out_wr_ff;
   logic [smr_pkg::OUT_PTR_W-1:0]        out_rd_ff;
   logic [smr_pkg::OUT_CNT_W-1:0]        occ_ff, occ_in;
   logic [smr_pkg::OUT_CNT_W:0]          committed;
   logic                                 out_pop;

   // Map the output position to the source position of the stored matrix.
   always_comb begin
      case (turns_ff)
         smr_pkg::TURN_90: begin
            src_row = LAST_IDX - col_ff;
            src_col = row_ff;
         end
         smr_pkg::TURN_180: begin
            src_row = LAST_IDX - row_ff;
            src_col = LAST_IDX - col_ff;
         end
         smr_pkg::TURN_270: begin
            src_row = col_ff;
            src_col = LAST_IDX - row_ff;
         end
         default: begin
            src_row = row_ff;
            src_col = col_ff;
         end
      endcase
      src_index = CNT_W'(src_row * MATRIX_SIZE) + CNT_W'(src_col);
   end

   // A read is issued only when the result queue has room for it and for one in flight.
   assign committed = {1'b0, occ_ff} + {{smr_pkg::OUT_CNT_W{1'b0}}, pend_ff};
   assign can_issue = (committed < (smr_pkg::OUT_CNT_W + 1)'(smr_pkg::OUT_DEPTH));
   assign issue     = (state_ff == BK_RUN) && can_issue;
   assign last_pos  = (row_ff == LAST_IDX) && (col_ff == LAST_IDX);
   assign cmd_pop   = (state_ff == BK_IDLE) && cmd_valid;

   // The bank is free again once its last element has been read.
   assign release_info.valid = issue & last_pos;
   assign release_info.bank  = bank_ff;

   // Sequencer over the rows and columns of the rotated matrix.
   always_comb begin
      state_in = state_ff;
      bank_in  = bank_ff;
      turns_in = turns_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               bank_in  = cmd.bank;
               turns_in = cmd.turns;
               row_in   = '0;
               col_in   = '0;
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (issue) begin
               if (col_ff == LAST_IDX) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (last_pos) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer payload needs no reset.
   always_ff @(posedge clock) begin
      bank_ff  <= bank_in;
      turns_ff <= turns_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
   end

   // Matrix store: one write port from the loader, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= store_ff[{bank_ff, src_index}];
         rd_last_ff <= last_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
      end
   end

   // Result queue; a read that lands is written in the cycle after it was issued.
   assign out_pop = pop & ~empty;

   always_comb begin
      occ_in = occ_ff;
      if (pend_ff && !out_pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (out_pop && !pend_ff) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff <= '0;
         out_rd_ff <= '0;
         occ_ff    <= '0;
      end else begin
         occ_ff <= occ_in;
         if (pend_ff) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         out_data_ff[out_wr_ff] <= rd_data_ff;
         out_last_ff[out_wr_ff] <= rd_last_ff;
      end
   end

   assign empty         = (occ_ff == '0);
   assign rotated_value = out_data_ff[out_rd_ff];
   assign run_end       = out_last_ff[out_rd_ff];

`ifndef SYNTHESIS
   // The result queue never overflows.
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= smr_pkg::OUT_CNT_W'(smr_pkg::OUT_DEPTH))
      else $error("result queue overflow");

   // Reading the final element ends the drain.
   assert property (@(posedge clock) disable iff (reset)
      (issue && last_pos) |=> (state_ff == BK_IDLE))
      else $error("drain did not end after the final element");

   // A command is taken only when no drain is running.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == BK_RUN) && (row_ff == '0) && (col_ff == '0))
      else $error("drain did not start at the first position");
`endif

endmodule
